/* hdl/stl_pkg.sv */
// ----------------------------------------------------------------------------
// stl_pkg
// Types, codes and character classes shared by the script token lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package stl_pkg;

  // Input transaction: one source byte or the end-of-input mark.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } char_item_t;

  // Output transaction: one result record.
  typedef struct packed {
    logic [1:0]  item_kind;
    logic [2:0]  token_kind;
    logic [5:0]  delim_code;
    logic [7:0]  text_byte;
    logic [15:0] line_number;
    logic [2:0]  error_code;
    logic        last_result;
  } res_item_t;

  // Room for the records of one input byte; one byte causes at most three.
  localparam int GROUP_SIZE = 4;
  localparam int GROUP_CNT_BITS = $clog2(GROUP_SIZE + 1);

  // All records caused by one input, as they travel from front to back.
  typedef struct packed {
    res_item_t [GROUP_SIZE-1:0] recs;
    logic [GROUP_CNT_BITS-1:0]  count;
  } group_t;

  // Record kinds.
  localparam logic [1:0] IK_TEXT  = 2'd0;
  localparam logic [1:0] IK_END   = 2'd1;
  localparam logic [1:0] IK_ERROR = 2'd2;
  localparam logic [1:0] IK_EOF   = 2'd3;

  // Token kinds.
  localparam logic [2:0] TK_DELIM = 3'd0;
  localparam logic [2:0] TK_STR   = 3'd1;
  localparam logic [2:0] TK_INT   = 3'd2;
  localparam logic [2:0] TK_FLOAT = 3'd3;
  localparam logic [2:0] TK_IDENT = 3'd4;

  // Error codes.
  localparam logic [2:0] ERR_ESCAPE  = 3'd0;
  localparam logic [2:0] ERR_QUOTE   = 3'd1;
  localparam logic [2:0] ERR_COMMENT = 3'd2;
  localparam logic [2:0] ERR_IDENT   = 3'd3;
  localparam logic [2:0] ERR_NUMBER  = 3'd4;
  localparam logic [2:0] ERR_HEX     = 3'd5;
  localparam logic [2:0] ERR_UNKNOWN = 3'd6;

  // Delimiter codes for doubled and compare pairs.
  localparam logic [5:0] DC_DOUBLE_BASE = 6'd23;
  localparam logic [5:0] DC_LE = 6'd30;
  localparam logic [5:0] DC_GE = 6'd31;
  localparam logic [5:0] DC_NE = 6'd32;

  // Returns {found, code} for a single delimiter.
  function automatic logic [6:0] single_index(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    case (c)
      "+": r = {1'b1, 6'd0};
      "-": r = {1'b1, 6'd1};
      "<": r = {1'b1, 6'd2};
      ">": r = {1'b1, 6'd3};
      "=": r = {1'b1, 6'd4};
      "&": r = {1'b1, 6'd5};
      "|": r = {1'b1, 6'd6};
      ".": r = {1'b1, 6'd7};
      "!": r = {1'b1, 6'd8};
      ";": r = {1'b1, 6'd9};
      ",": r = {1'b1, 6'd10};
      "/": r = {1'b1, 6'd11};
      "*": r = {1'b1, 6'd12};
      "%": r = {1'b1, 6'd13};
      "^": r = {1'b1, 6'd14};
      "(": r = {1'b1, 6'd15};
      ")": r = {1'b1, 6'd16};
      "[": r = {1'b1, 6'd17};
      "]": r = {1'b1, 6'd18};
      "{": r = {1'b1, 6'd19};
      "}": r = {1'b1, 6'd20};
      ":": r = {1'b1, 6'd21};
      "~": r = {1'b1, 6'd22};
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  // Delimiters that may be doubled map to their place in the first seven.
  function automatic logic is_doubling(input logic [7:0] c);
    return (c == "+") || (c == "-") || (c == "<") || (c == ">") ||
           (c == "=") || (c == "&") || (c == "|");
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
           (c == 8'h0C) || (c == 8'h0D);
  endfunction

  // Characters that may end an identifier or number.
  function automatic logic is_term(input logic [7:0] c);
    logic [6:0] s;
    s = single_index(c);
    return s[6] || (c == 8'h20) || (c == 8'h09) || (c == 8'h0A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  // Returns {valid, value} of a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if ((c >= "0") && (c <= "9")) begin
      r = {1'b1, 4'(c - "0")};
    end else if ((c >= "a") && (c <= "f")) begin
      r = {1'b1, 4'(c - "a" + 8'd10)};
    end else if ((c >= "A") && (c <= "F")) begin
      r = {1'b1, 4'(c - "A" + 8'd10)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/stl_front.sv */
// ----------------------------------------------------------------------------
// stl_front
// Lexer state machine: takes one byte per cycle while the queue is not full and forms the group of
// records that byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_front #(
  parameter int LINE_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              char_valid,
  output logic                   char_ready,
  input  wire stl_pkg::char_item_t char_data,
  input  wire logic              queue_full,
  output logic                   push,
  output stl_pkg::group_t        push_group
);
  import stl_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE, M_DELIM, M_LCOM, M_BCOM, M_BSTAR, M_STR, M_ESC,
    M_OCT, M_HEX0, M_HEX1, M_IDENT, M_NUM
  } mode_t;

  localparam int LW = (LINE_BITS > 16) ? LINE_BITS : 16;
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

  mode_t                 mode, mode_next;
  logic [7:0]            held, held_next;
  logic [7:0]            quote, quote_next;
  logic [7:0]            esc_val, esc_val_next;
  logic [1:0]            esc_dig, esc_dig_next;
  logic [2:0]            phase, phase_next;
  logic [LINE_BITS-1:0]  line_count, line_count_next;
  logic                  halted, halted_next;

  logic                  take;
  logic [7:0]            ch;
  logic [15:0]           line_field;
  res_item_t [GROUP_SIZE-1:0] recs;
  logic [GROUP_CNT_BITS-1:0]  n;
  logic                  do_start;
  logic                  do_str;
  logic [6:0]            sidx;
  logic [4:0]            hv;
  logic [7:0]            v;

  assign char_ready = !queue_full;
  assign take = char_valid && char_ready;
  assign ch = char_data.char_byte;

  // Line reported in records, saturated to the field width.
  assign line_field = (LW'(line_count) > LW'(16'hFFFF)) ? 16'hFFFF : 16'(line_count);

  function automatic res_item_t mk(input logic [1:0] ik, input logic [2:0] tk,
                                   input logic [5:0] dc, input logic [7:0] tb,
                                   input logic [2:0] ec, input logic [15:0] ln);
    res_item_t r;
    r.item_kind   = ik;
    r.token_kind  = tk;
    r.delim_code  = dc;
    r.text_byte   = tb;
    r.line_number = ln;
    r.error_code  = ec;
    r.last_result = 1'b0;
    return r;
  endfunction

  // Next-state and record formation for one transaction.
  always_comb begin
    mode_next       = mode;
    held_next       = held;
    quote_next      = quote;
    esc_val_next    = esc_val;
    esc_dig_next    = esc_dig;
    phase_next      = phase;
    line_count_next = line_count;
    halted_next     = halted;
    recs            = '0;
    n               = '0;
    do_start        = 1'b0;
    do_str          = 1'b0;
    sidx            = single_index(held);
    hv              = hex_val(ch);
    v               = 8'd0;

    if (!halted && char_data.end_of_input) begin
      // Close what is pending at end of text.
      case (mode)
        M_DELIM: begin
          recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, held, 3'd0, line_field); n = n + 1'b1;
          recs[n[1:0]] = mk(IK_END, TK_DELIM, sidx[5:0], 8'd0, 3'd0, line_field);
          n = n + 1'b1;
        end
        M_BCOM, M_BSTAR: begin
          recs[n[1:0]] = mk(IK_ERROR, 3'd0, 6'd0, 8'd0, ERR_COMMENT, line_field);
          n = n + 1'b1; halted_next = 1'b1;
        end
        M_STR, M_ESC, M_OCT, M_HEX0, M_HEX1: begin
          recs[n[1:0]] = mk(IK_ERROR, 3'd0, 6'd0, 8'd0, ERR_QUOTE, line_field);
          n = n + 1'b1; halted_next = 1'b1;
        end
        M_IDENT: begin
          recs[n[1:0]] = mk(IK_END, TK_IDENT, 6'd0, 8'd0, 3'd0, line_field); n = n + 1'b1;
        end
        M_NUM: begin
          if (phase <= 3'd1 || phase == 3'd7) begin
            recs[n[1:0]] = mk(IK_END, TK_INT, 6'd0, 8'd0, 3'd0, line_field);
            n = n + 1'b1;
          end else if (phase == 3'd2 || phase == 3'd5) begin
            recs[n[1:0]] = mk(IK_END, TK_FLOAT, 6'd0, 8'd0, 3'd0, line_field);
            n = n + 1'b1;
          end else begin
            recs[n[1:0]] = mk(IK_ERROR, 3'd0, 6'd0, 8'd0, ERR_NUMBER, line_field);
            n = n + 1'b1; halted_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (!halted_next) begin
        recs[n[1:0]] = mk(IK_EOF, 3'd0, 6'd0, 8'd0, 3'd0, line_field); n = n + 1'b1;
        mode_next       = M_IDLE;
        held_next       = 8'd0;
        quote_next      = 8'd0;
        esc_val_next    = 8'd0;
        esc_dig_next    = 2'd0;
        phase_next      = 3'd0;
        line_count_next = LINE_BITS'(1);
      end
    end else if (!halted && ch != 8'd0) begin
      case (mode)
        M_DELIM: begin
          if (held == "/" && ch == "/") begin
            mode_next = M_LCOM;
          end else if (held == "/" && ch == "*") begin
            mode_next = M_BCOM;
          end else if (is_doubling(held) && ch == held) begin
            recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, held, 3'd0, line_field); n = n + 1'b1;
            recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, ch, 3'd0, line_field); n = n + 1'b1;
            recs[n[1:0]] = mk(IK_END, TK_DELIM, DC_DOUBLE_BASE + sidx[5:0], 8'd0, 3'd0,
                              line_field);
            n = n + 1'b1;
            mode_next = M_IDLE;
          end else if (ch == "=" && (held == "<" || held == ">" || held == "!")) begin
            recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, held, 3'd0, line_field); n = n + 1'b1;
            recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, ch, 3'd0, line_field); n = n + 1'b1;
            recs[n[1:0]] = mk(IK_END, TK_DELIM,
                              (held == "<") ? DC_LE : ((held == ">") ? DC_GE : DC_NE),
                              8'd0, 3'd0, line_field);
            n = n + 1'b1;
            mode_next = M_IDLE;
          end else begin
            recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, held, 3'd0, line_field); n = n + 1'b1;
            recs[n[1:0]] = mk(IK_END, TK_DELIM, sidx[5:0], 8'd0, 3'd0, line_field);
            n = n + 1'b1;
            do_start = 1'b1;
          end
        end
        M_LCOM: begin
          if (ch == 8'h0A) begin
            mode_next = M_IDLE;
          end
        end
        M_BCOM: begin
          if (ch == "*") begin
            mode_next = M_BSTAR;
          end
        end
        M_BSTAR: begin
          if (ch == "/") begin
            mode_next = M_IDLE;
          end else if (ch != "*") begin
            mode_next = M_BCOM;
          end
        end
        M_STR: begin
          do_str = 1'b1;
        end
        M_ESC: begin
          mode_next = M_STR;
          if (ch == quote) begin
            recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, ch, 3'd0, line_field); n = n + 1'b1;
          end else if (ch == "n") begin
            recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, 8'h0A, 3'd0, line_field); n = n + 1'b1;
          end else if (ch == "r") begin
            recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, 8'h0D, 3'd0, line_field); n = n + 1'b1;
          end else if (ch == "t") begin
            recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, 8'h09, 3'd0, line_field); n = n + 1'b1;
          end else if (ch == 8'h5C) begin
            recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, 8'h5C, 3'd0, line_field); n = n + 1'b1;
          end else if (ch == 8'h0A) begin
            // Line continuation inside a string yields nothing.
          end else if (ch >= "0" && ch <= "7") begin
            esc_val_next = {5'd0, ch[2:0]};
            esc_dig_next = 2'd1;
            mode_next    = M_OCT;
          end else if (ch == "x") begin
            mode_next = M_HEX0;
          end else begin
            recs[n[1:0]] = mk(IK_ERROR, 3'd0, 6'd0, 8'd0, ERR_ESCAPE, line_field);
            n = n + 1'b1; halted_next = 1'b1;
          end
        end
        M_OCT: begin
          if (ch >= "0" && ch <= "7") begin
            v = {esc_val[4:0], ch[2:0]};
            esc_val_next = v;
            esc_dig_next = esc_dig + 2'd1;
            if (esc_dig_next == 2'd3) begin
              if (v != 8'd0) begin
                recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, v, 3'd0, line_field); n = n + 1'b1;
              end
              mode_next = M_STR;
            end
          end else begin
            if (esc_val != 8'd0) begin
              recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, esc_val, 3'd0, line_field);
              n = n + 1'b1;
            end
            mode_next = M_STR;
            do_str = 1'b1;
          end
        end
        M_HEX0: begin
          if (hv[4]) begin
            esc_val_next = {4'd0, hv[3:0]};
            mode_next    = M_HEX1;
          end else begin
            recs[n[1:0]] = mk(IK_ERROR, 3'd0, 6'd0, 8'd0, ERR_ESCAPE, line_field);
            n = n + 1'b1; halted_next = 1'b1;
          end
        end
        M_HEX1: begin
          if (hv[4]) begin
            v = {esc_val[3:0], hv[3:0]};
            esc_val_next = v;
            if (v != 8'd0) begin
              recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, v, 3'd0, line_field); n = n + 1'b1;
            end
            mode_next = M_STR;
          end else begin
            if (esc_val != 8'd0) begin
              recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, esc_val, 3'd0, line_field);
              n = n + 1'b1;
            end
            mode_next = M_STR;
            do_str = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(ch) || is_digit(ch)) begin
            recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, ch, 3'd0, line_field); n = n + 1'b1;
          end else if (is_term(ch)) begin
            recs[n[1:0]] = mk(IK_END, TK_IDENT, 6'd0, 8'd0, 3'd0, line_field); n = n + 1'b1;
            do_start = 1'b1;
          end else begin
            recs[n[1:0]] = mk(IK_ERROR, 3'd0, 6'd0, 8'd0, ERR_IDENT, line_field);
            n = n + 1'b1; halted_next = 1'b1;
          end
        end
        M_NUM: begin
          case (phase)
            3'd0, 3'd1: begin
              if (phase == 3'd1 && (ch == "x" || ch == "X")) begin
                recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, ch, 3'd0, line_field); n = n + 1'b1;
                phase_next = 3'd6;
              end else if (is_digit(ch)) begin
                recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, ch, 3'd0, line_field); n = n + 1'b1;
                phase_next = 3'd0;
              end else if (ch == ".") begin
                recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, ch, 3'd0, line_field); n = n + 1'b1;
                phase_next = 3'd2;
              end else if (ch == "e" || ch == "E") begin
                recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, ch, 3'd0, line_field); n = n + 1'b1;
                phase_next = 3'd3;
              end else if (is_term(ch)) begin
                recs[n[1:0]] = mk(IK_END, TK_INT, 6'd0, 8'd0, 3'd0, line_field);
                n = n + 1'b1; do_start = 1'b1;
              end else begin
                recs[n[1:0]] = mk(IK_ERROR, 3'd0, 6'd0, 8'd0, ERR_NUMBER, line_field);
                n = n + 1'b1; halted_next = 1'b1;
              end
            end
            3'd2: begin
              if (is_digit(ch)) begin
                recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, ch, 3'd0, line_field); n = n + 1'b1;
              end else if (ch == "e" || ch == "E") begin
                recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, ch, 3'd0, line_field); n = n + 1'b1;
                phase_next = 3'd3;
              end else if (is_term(ch)) begin
                recs[n[1:0]] = mk(IK_END, TK_FLOAT, 6'd0, 8'd0, 3'd0, line_field);
                n = n + 1'b1; do_start = 1'b1;
              end else begin
                recs[n[1:0]] = mk(IK_ERROR, 3'd0, 6'd0, 8'd0, ERR_NUMBER, line_field);
                n = n + 1'b1; halted_next = 1'b1;
              end
            end
            3'd3: begin
              if (ch == "+" || ch == "-") begin
                recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, ch, 3'd0, line_field); n = n + 1'b1;
                phase_next = 3'd4;
              end else if (is_digit(ch)) begin
                recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, ch, 3'd0, line_field); n = n + 1'b1;
                phase_next = 3'd5;
              end else begin
                recs[n[1:0]] = mk(IK_ERROR, 3'd0, 6'd0, 8'd0, ERR_NUMBER, line_field);
                n = n + 1'b1; halted_next = 1'b1;
              end
            end
            3'd4: begin
              if (is_digit(ch)) begin
                recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, ch, 3'd0, line_field); n = n + 1'b1;
                phase_next = 3'd5;
              end else begin
                recs[n[1:0]] = mk(IK_ERROR, 3'd0, 6'd0, 8'd0, ERR_NUMBER, line_field);
                n = n + 1'b1; halted_next = 1'b1;
              end
            end
            3'd5: begin
              if (is_digit(ch)) begin
                recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, ch, 3'd0, line_field); n = n + 1'b1;
              end else if (is_term(ch)) begin
                recs[n[1:0]] = mk(IK_END, TK_FLOAT, 6'd0, 8'd0, 3'd0, line_field);
                n = n + 1'b1; do_start = 1'b1;
              end else begin
                recs[n[1:0]] = mk(IK_ERROR, 3'd0, 6'd0, 8'd0, ERR_NUMBER, line_field);
                n = n + 1'b1; halted_next = 1'b1;
              end
            end
            3'd6: begin
              if (hv[4]) begin
                recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, ch, 3'd0, line_field); n = n + 1'b1;
                phase_next = 3'd7;
              end else begin
                recs[n[1:0]] = mk(IK_ERROR, 3'd0, 6'd0, 8'd0, ERR_NUMBER, line_field);
                n = n + 1'b1; halted_next = 1'b1;
              end
            end
            default: begin
              if (hv[4]) begin
                recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, ch, 3'd0, line_field); n = n + 1'b1;
              end else if (is_term(ch)) begin
                recs[n[1:0]] = mk(IK_END, TK_INT, 6'd0, 8'd0, 3'd0, line_field);
                n = n + 1'b1; do_start = 1'b1;
              end else begin
                recs[n[1:0]] = mk(IK_ERROR, 3'd0, 6'd0, 8'd0, ERR_HEX, line_field);
                n = n + 1'b1; halted_next = 1'b1;
              end
            end
          endcase
        end
        default: begin
          do_start = 1'b1;
        end
      endcase

      // A byte inside a string body.
      if (do_str) begin
        if (ch == quote) begin
          recs[n[1:0]] = mk(IK_END, TK_STR, 6'd0, 8'd0, 3'd0, line_field); n = n + 1'b1;
          mode_next = M_IDLE;
        end else if (ch == 8'h5C) begin
          mode_next = M_ESC;
        end else begin
          recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, ch, 3'd0, line_field); n = n + 1'b1;
        end
      end

      // A byte seen between tokens starts the next one.
      if (do_start) begin
        mode_next = M_IDLE;
        if (is_ws(ch)) begin
          // Skipped.
        end else if (single_index(ch) >= 7'h40) begin
          held_next = ch;
          mode_next = M_DELIM;
        end else if (ch == 8'h22 || ch == 8'h27) begin
          quote_next = ch;
          mode_next  = M_STR;
        end else if (is_alpha(ch)) begin
          recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, ch, 3'd0, line_field); n = n + 1'b1;
          mode_next = M_IDENT;
        end else if (is_digit(ch)) begin
          recs[n[1:0]] = mk(IK_TEXT, 3'd0, 6'd0, ch, 3'd0, line_field); n = n + 1'b1;
          phase_next = (ch == "0") ? 3'd1 : 3'd0;
          mode_next  = M_NUM;
        end else begin
          recs[n[1:0]] = mk(IK_ERROR, 3'd0, 6'd0, 8'd0, ERR_UNKNOWN, line_field);
          n = n + 1'b1; halted_next = 1'b1;
        end
      end

      // Newlines count lines after the records are formed.
      if (ch == 8'h0A && line_count != LINE_MAX) begin
        line_count_next = line_count + 1'b1;
      end
    end
  end

  assign push             = take && (n != '0);
  assign push_group.recs  = recs;
  assign push_group.count = n;

  // Lexer state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      held       <= 8'd0;
      quote      <= 8'd0;
      esc_val    <= 8'd0;
      esc_dig    <= 2'd0;
      phase      <= 3'd0;
      line_count <= LINE_BITS'(1);
      halted     <= 1'b0;
    end else if (take) begin
      mode       <= mode_next;
      held       <= held_next;
      quote      <= quote_next;
      esc_val    <= esc_val_next;
      esc_dig    <= esc_dig_next;
      phase      <= phase_next;
      line_count <= line_count_next;
      halted     <= halted_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/stl_queue.sv */
// ----------------------------------------------------------------------------
// stl_queue
// Two-entry queue of record groups between the lexer and the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire stl_pkg::group_t push_group,
  input  wire logic            pop,
  output logic                 full,
  output logic                 empty,
  output stl_pkg::group_t      head
);
  import stl_pkg::*;

  group_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign head  = slots[rd_ptr];

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_group;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/stl_back.sv */
// ----------------------------------------------------------------------------
// stl_back
// Serializer: hands out the records of the head group one per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            empty,
  input  wire stl_pkg::group_t head,
  output logic                 pop,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output stl_pkg::res_item_t   res_data
);
  import stl_pkg::*;

  logic [1:0] idx;
  logic       last;

  assign last      = ({1'b0, idx} == (head.count - 1'b1));
  assign res_valid = !empty;
  assign pop       = res_valid && res_ready && last;

  // Current record, with the last mark set on the final one of the group.
  always_comb begin
    res_data             = head.recs[idx];
    res_data.last_result = last;
  end

  // Record index within the head group.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (res_valid && res_ready) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

`default_nettype wire

/* hdl/script_token_lexer_core.sv */
// Throughput: one byte per cycle while the queue is not full; a byte causes 0 to 3
// records, and the serializer hands them out one per output transaction.
// A two-group queue between the lexer and the serializer absorbs stalls.
// Reset (rst, synchronous): lexer to idle, line count to one, queue emptied.
// ----------------------------------------------------------------------------
// script_token_lexer_core
// Streaming lexer top level: lexer front end, group queue, serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module script_token_lexer_core #(
  parameter int LINE_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                char_valid,
  output logic                     char_ready,
  input  wire stl_pkg::char_item_t char_data,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output stl_pkg::res_item_t       res_data
);
  import stl_pkg::*;

  logic   push;
  logic   pop;
  logic   full;
  logic   empty;
  group_t push_group;
  group_t head;

  // Lexer state machine.
  stl_front #(.LINE_BITS(LINE_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_data  (char_data),
    .queue_full (full),
    .push       (push),
    .push_group (push_group)
  );

  // Group queue.
  stl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .pop        (pop),
    .full       (full),
    .empty      (empty),
    .head       (head)
  );

  // Record serializer.
  stl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule

`default_nettype wire

/* hdl/stl_checker.sv */
// ----------------------------------------------------------------------------
// stl_checker
// Port-level checks on the lexer's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               res_valid,
  input wire logic               res_ready,
  input wire stl_pkg::res_item_t res_data
);
  import stl_pkg::*;

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

  // Nothing is offered right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result offered after reset");

  // An error ends its group.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.item_kind == IK_ERROR |-> res_data.last_result)
    else $error("error record not last");

  // After an error transaction the block goes silent.
  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res_data.item_kind == IK_ERROR |=> !res_valid)
    else $error("result after error");

  // Text records carry no token kind or error code.
  a_text: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.item_kind == IK_TEXT |->
      res_data.token_kind == 3'd0 && res_data.error_code == 3'd0)
    else $error("text record with stray fields");

endmodule

bind script_token_lexer_core stl_checker u_stl_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res_valid),
  .res_ready  (res_ready),
  .res_data   (res_data)
);

`default_nettype wire
